[rtl/core/fenwick_order_statistic_multiset_assert.svh]
// assertion macros for the order-statistic multiset
`ifndef FENWICK_ORDER_STATISTIC_MULTISET_ASSERT_SVH
`define FENWICK_ORDER_STATISTIC_MULTISET_ASSERT_SVH

// same-cycle implication under synchronous reset
`define FOSM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fosm assertion failed");

// next-cycle implication under synchronous reset
`define FOSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fosm assertion failed");

`endif

[rtl/core/fosm_pkg.sv]
// shared types and codes for the order-statistic multiset
package fosm_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [16:0] key;
        logic [31:0] rank;
    } t_in_beat;

    typedef struct packed {
        logic [16:0] found_key;
        logic [1:0]  status;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_DESC_RD,
        S_DESC_CMP,
        S_DESC_END,
        S_WALK_RD,
        S_WALK_WR
    } t_fosm_state;

    typedef struct packed {
        logic       clr_step;
        logic       load_item;
        logic       set_err;
        logic [1:0] err_code;
        logic       start_walk;
        logic       start_desc;
        logic       desc_rd;
        logic       desc_skip;
        logic       desc_cmp;
        logic       desc_end;
        logic       walk_rd;
        logic       walk_wr;
        logic       walk_end;
        logic       out_load;
    } t_fosm_cmd;

    typedef struct packed {
        logic op;
        logic key_bad;
        logic full;
        logic rank_bad;
        logic probe_in;
        logic step_last;
        logic pos_in;
        logic clr_last;
        logic out_free;
    } t_fosm_sts;

endpackage

[rtl/core/fosm_ctrl.sv]
// controller state machine sequencing clear, descent and tree walks
module fosm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fosm_pkg::t_fosm_sts  i_sts,
    output fosm_pkg::t_fosm_cmd  o_cmd
);

    fosm_pkg::t_fosm_state r_state;
    fosm_pkg::t_fosm_state n_state;
    logic                  r_done;
    logic                  n_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fosm_pkg::S_CLEAR;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        case (r_state)
            fosm_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = fosm_pkg::S_IDLE;
            end
            fosm_pkg::S_IDLE: begin
                if (r_done) begin
                    if (i_sts.out_free) n_done = 1'b0;
                end else if (i_in_valid) begin
                    n_state = fosm_pkg::S_CHECK;
                end
            end
            fosm_pkg::S_CHECK: begin
                if (i_sts.op == fosm_pkg::OP_INSERT) begin
                    if (i_sts.key_bad || i_sts.full) begin
                        n_state = fosm_pkg::S_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_state = fosm_pkg::S_WALK_RD;
                    end
                end else begin
                    if (i_sts.rank_bad) begin
                        n_state = fosm_pkg::S_IDLE;
                        n_done  = 1'b1;
                    end else begin
                        n_state = fosm_pkg::S_DESC_RD;
                    end
                end
            end
            fosm_pkg::S_DESC_RD: begin
                if (i_sts.probe_in) n_state = fosm_pkg::S_DESC_CMP;
                else if (i_sts.step_last) n_state = fosm_pkg::S_DESC_END;
            end
            fosm_pkg::S_DESC_CMP: begin
                if (i_sts.step_last) n_state = fosm_pkg::S_DESC_END;
                else n_state = fosm_pkg::S_DESC_RD;
            end
            fosm_pkg::S_DESC_END: begin
                n_state = fosm_pkg::S_WALK_RD;
            end
            fosm_pkg::S_WALK_RD: begin
                if (i_sts.pos_in) begin
                    n_state = fosm_pkg::S_WALK_WR;
                end else begin
                    n_state = fosm_pkg::S_IDLE;
                    n_done  = 1'b1;
                end
            end
            fosm_pkg::S_WALK_WR: begin
                n_state = fosm_pkg::S_WALK_RD;
            end
            default: begin
                n_state = fosm_pkg::S_CLEAR;
                n_done  = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            fosm_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            fosm_pkg::S_IDLE: begin
                if (r_done) begin
                    o_cmd.out_load = i_sts.out_free;
                end else begin
                    o_in_ready      = 1'b1;
                    o_cmd.load_item = i_in_valid;
                end
            end
            fosm_pkg::S_CHECK: begin
                if (i_sts.op == fosm_pkg::OP_INSERT) begin
                    if (i_sts.key_bad) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = fosm_pkg::ST_RANGE;
                    end else if (i_sts.full) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = fosm_pkg::ST_FULL;
                    end else begin
                        o_cmd.start_walk = 1'b1;
                    end
                end else begin
                    if (i_sts.rank_bad) begin
                        o_cmd.set_err  = 1'b1;
                        o_cmd.err_code = fosm_pkg::ST_RANGE;
                    end else begin
                        o_cmd.start_desc = 1'b1;
                    end
                end
            end
            fosm_pkg::S_DESC_RD: begin
                if (i_sts.probe_in) o_cmd.desc_rd = 1'b1;
                else o_cmd.desc_skip = 1'b1;
            end
            fosm_pkg::S_DESC_CMP: begin
                o_cmd.desc_cmp = 1'b1;
            end
            fosm_pkg::S_DESC_END: begin
                o_cmd.desc_end = 1'b1;
            end
            fosm_pkg::S_WALK_RD: begin
                if (i_sts.pos_in) o_cmd.walk_rd = 1'b1;
                else o_cmd.walk_end = 1'b1;
            end
            fosm_pkg::S_WALK_WR: begin
                o_cmd.walk_wr = 1'b1;
            end
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/fosm_dp.sv]
// datapath: count tree memory, descent and walk registers, total and result beat
module fosm_dp #(
    parameter int UNIVERSE   = 65536,
    parameter int COUNT_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fosm_pkg::t_in_beat   i_in_beat,
    input  fosm_pkg::t_fosm_cmd  i_cmd,
    output fosm_pkg::t_fosm_sts  o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fosm_pkg::t_out_beat  o_out_beat
);

    localparam int AW      = $clog2(UNIVERSE);
    localparam int PW      = AW + 2;
    localparam int WW      = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam int TOP_LOG = $clog2(UNIVERSE + 1) - 1;

    // tree node counts, node n at address n - 1
    logic [COUNT_BITS-1:0] mem [UNIVERSE];
    logic [COUNT_BITS-1:0] r_rd_data;

    logic                  r_op;
    logic [16:0]           r_key;
    logic [31:0]           r_rank;
    logic [PW-1:0]         r_pos,       n_pos;
    logic [PW-1:0]         r_step,      n_step;
    logic [WW-1:0]         r_want,      n_want;
    logic [AW-1:0]         r_clr_addr,  n_clr_addr;
    logic [COUNT_BITS-1:0] r_total,     n_total;
    logic [16:0]           r_res_key,   n_res_key;
    logic [1:0]            r_res_stat,  n_res_stat;
    logic                  r_out_valid, n_out_valid;
    fosm_pkg::t_out_beat   r_out_beat,  n_out_beat;

    logic [PW-1:0]         w_probe;
    logic [PW-1:0]         w_probe_m1;
    logic [PW-1:0]         w_pos_m1;
    logic [PW-1:0]         w_nxt;
    logic [PW-1:0]         w_found;
    logic [PW-1:0]         w_lowbit;
    logic [WW-1:0]         w_rd_ext;
    logic                  w_less;
    logic [AW-1:0]         w_addr;
    logic                  w_we;
    logic [COUNT_BITS-1:0] w_wdata;
    logic                  w_out_free;

    assign w_probe    = r_pos + r_step;
    assign w_probe_m1 = w_probe - PW'(1);
    assign w_pos_m1   = r_pos - PW'(1);
    assign w_nxt      = r_pos + PW'(1);
    assign w_found    = (w_nxt > PW'(UNIVERSE)) ? PW'(UNIVERSE) : w_nxt;
    assign w_lowbit   = r_pos & (~r_pos + PW'(1));
    assign w_rd_ext   = WW'(r_rd_data);
    assign w_less     = w_rd_ext < r_want;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_addr  = i_cmd.clr_step ? r_clr_addr :
                     i_cmd.desc_rd  ? w_probe_m1[AW-1:0] : w_pos_m1[AW-1:0];
    assign w_we    = i_cmd.clr_step || i_cmd.walk_wr;
    assign w_wdata = i_cmd.clr_step ? '0 :
                     (r_op == fosm_pkg::OP_TAKE) ? r_rd_data - COUNT_BITS'(1)
                                                 : r_rd_data + COUNT_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_addr] <= w_wdata;
        r_rd_data <= mem[w_addr];
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.key_bad   = (r_key == 17'd0) || (32'(r_key) > 32'(UNIVERSE));
        o_sts.full      = (r_total == '1);
        o_sts.rank_bad  = (r_rank == 32'd0) || (WW'(r_rank) > WW'(r_total));
        o_sts.probe_in  = (w_probe <= PW'(UNIVERSE));
        o_sts.step_last = (r_step == PW'(1));
        o_sts.pos_in    = (r_pos <= PW'(UNIVERSE));
        o_sts.clr_last  = (r_clr_addr == AW'(UNIVERSE - 1));
        o_sts.out_free  = w_out_free;
    end

    always_comb begin
        n_pos       = r_pos;
        n_step      = r_step;
        n_want      = r_want;
        n_clr_addr  = r_clr_addr;
        n_total     = r_total;
        n_res_key   = r_res_key;
        n_res_stat  = r_res_stat;
        n_out_valid = r_out_valid;
        n_out_beat  = r_out_beat;

        if (i_cmd.clr_step) n_clr_addr = r_clr_addr + AW'(1);
        if (i_cmd.set_err) begin
            n_res_key  = 17'd0;
            n_res_stat = i_cmd.err_code;
        end
        if (i_cmd.start_walk) begin
            n_pos     = PW'(r_key);
            n_res_key = r_key;
        end
        if (i_cmd.start_desc) begin
            n_pos  = '0;
            n_step = PW'(1) << TOP_LOG;
            n_want = WW'(r_rank);
        end
        if (i_cmd.desc_skip) n_step = r_step >> 1;
        if (i_cmd.desc_cmp) begin
            n_step = r_step >> 1;
            if (w_less) begin
                n_want = r_want - w_rd_ext;
                n_pos  = w_probe;
            end
        end
        if (i_cmd.desc_end) begin
            n_pos     = w_found;
            n_res_key = 17'(w_found);
        end
        if (i_cmd.walk_wr) n_pos = r_pos + w_lowbit;
        if (i_cmd.walk_end) begin
            n_res_stat = fosm_pkg::ST_OK;
            n_total    = (r_op == fosm_pkg::OP_TAKE) ? r_total - COUNT_BITS'(1)
                                                     : r_total + COUNT_BITS'(1);
        end
        if (i_cmd.out_load) begin
            n_out_valid          = 1'b1;
            n_out_beat.found_key = r_res_key;
            n_out_beat.status    = r_res_stat;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_addr  <= n_clr_addr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_in_beat.op;
            r_key  <= i_in_beat.key;
            r_rank <= i_in_beat.rank;
        end
        r_pos      <= n_pos;
        r_step     <= n_step;
        r_want     <= n_want;
        r_res_key  <= n_res_key;
        r_res_stat <= n_res_stat;
        r_out_beat <= n_out_beat;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

[rtl/core/fenwick_order_statistic_multiset.sv]
// top level of the order-statistic multiset over a count tree in one memory
// an insert walks upward from its key, reading and then writing each node on the path
// a take first descends, reading in-range probes and skipping the rest, then walks upward
// one item at a time, paced by the single-port tree memory
// a finished beat waits in the output register; the next item is taken once it is loaded
// after reset a sweep over all UNIVERSE addresses zeroes the tree, o_in_ready low throughout
`include "fenwick_order_statistic_multiset_assert.svh"

module fenwick_order_statistic_multiset #(
    parameter int UNIVERSE   = 65536,
    parameter int COUNT_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fosm_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fosm_pkg::t_out_beat o_out_beat
);

    fosm_pkg::t_fosm_cmd w_cmd;
    fosm_pkg::t_fosm_sts w_sts;

    fosm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    fosm_dp #(
        .UNIVERSE   (UNIVERSE),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_beat   (i_in_beat),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    `FOSM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `FOSM_ASSERT_NOW(a_load_only_when_free, i_clk, i_rst_n, w_cmd.out_load, w_sts.out_free)
    `FOSM_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, w_cmd.clr_step, !o_in_ready)

endmodule

[test/tb.sv]
// testbench for the order-statistic multiset: random and directed items, scoreboard check
module tb;

    localparam int          UNIVERSE   = 65536;
    localparam int          COUNT_BITS = 32;
    localparam int          RANDOM_ITEMS = 1600;
    localparam int          IDLE_LIMIT = 300000;
    localparam logic [31:0] COUNT_MAX  = 32'hFFFF_FFFF;

    class order_stat_board;
        bit [31:0]            node_count [0:UNIVERSE];
        bit [31:0]            total;
        fosm_pkg::t_out_beat  pending_answers[$];
        int                   errors;

        function void walk_counts(int unsigned pos, bit up);
            while (pos >= 1 && pos <= UNIVERSE) begin
                node_count[pos] = up ? node_count[pos] + 1 : node_count[pos] - 1;
                pos += pos & (~pos + 1);
            end
        endfunction

        function int unsigned descend_rank(bit [31:0] want);
            int unsigned top;
            int unsigned pos;
            int unsigned probe;
            top = 1;
            pos = 0;
            while ((top << 1) <= UNIVERSE) top <<= 1;
            for (int unsigned step = top; step > 0; step >>= 1) begin
                probe = pos + step;
                if (probe <= UNIVERSE && node_count[probe] < want) begin
                    want -= node_count[probe];
                    pos = probe;
                end
            end
            return pos + 1;
        endfunction

        function void note_request(fosm_pkg::t_in_beat b);
            fosm_pkg::t_out_beat ans;
            int unsigned         hit;
            ans.found_key = '0;
            ans.status    = fosm_pkg::ST_OK;
            if (b.op == fosm_pkg::OP_INSERT) begin
                if (b.key < 1 || b.key > UNIVERSE) begin
                    ans.status = fosm_pkg::ST_RANGE;
                end else if (total >= COUNT_MAX) begin
                    ans.status = fosm_pkg::ST_FULL;
                end else begin
                    walk_counts(b.key, 1'b1);
                    total++;
                    ans.found_key = b.key;
                end
            end else begin
                if (b.rank == 0 || b.rank > total) begin
                    ans.status = fosm_pkg::ST_RANGE;
                end else begin
                    hit = descend_rank(b.rank);
                    if (hit > UNIVERSE) hit = UNIVERSE;
                    walk_counts(hit, 1'b0);
                    total--;
                    ans.found_key = 17'(hit);
                end
            end
            pending_answers.push_back(ans);
        endfunction

        function void check_answer(fosm_pkg::t_out_beat got);
            fosm_pkg::t_out_beat want;
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual key %0d status %0d",
                         $time, got.found_key, got.status);
                errors++;
                return;
            end
            want = pending_answers.pop_front();
            if (got.found_key !== want.found_key) begin
                $display("%0t found_key mismatch: expected %0d, actual %0d",
                         $time, want.found_key, got.found_key);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t status mismatch: expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                i_out_ready = 1'b0;
    fosm_pkg::t_in_beat  i_in_beat   = '0;
    logic                o_in_ready;
    logic                o_out_valid;
    fosm_pkg::t_out_beat o_out_beat;

    order_stat_board board = new();
    int unsigned     idle_cycles = 0;
    bit              calm_in  = 1'b0;
    bit              calm_out = 1'b0;
    int unsigned     sent = 0;

    fenwick_order_statistic_multiset #(
        .UNIVERSE  (UNIVERSE),
        .COUNT_BITS(COUNT_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_beat (o_out_beat)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) board.check_answer(o_out_beat);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(fosm_pkg::t_in_beat b);
        int unsigned gap;
        if (sent % 64 == 0) calm_in = ($urandom_range(0, 3) == 0);
        gap = calm_in ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_beat  <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(b);
        sent++;
    endtask

    task automatic send_op(logic op, logic [16:0] key, logic [31:0] rank);
        fosm_pkg::t_in_beat b;
        b.op   = op;
        b.key  = key;
        b.rank = rank;
        send_request(b);
    endtask

    function automatic fosm_pkg::t_in_beat random_request();
        fosm_pkg::t_in_beat b;
        int unsigned        roll;
        bit [31:0]          held;
        held   = board.total;
        b.key  = 17'($urandom_range(0, 131071));
        b.rank = $urandom();
        roll   = $urandom_range(0, 99);
        if (roll < 12) begin
            case ($urandom_range(0, 3))
                0: begin
                    b.op  = fosm_pkg::OP_INSERT;
                    b.key = $urandom_range(0, 1) ? 17'd0 : 17'($urandom_range(65537, 131071));
                end
                1: begin
                    b.op   = fosm_pkg::OP_TAKE;
                    b.rank = '0;
                end
                2: begin
                    b.op   = fosm_pkg::OP_TAKE;
                    b.rank = held + 1 + $urandom_range(0, 3);
                end
                default: b.op = fosm_pkg::OP_TAKE;
            endcase
        end else if (held == 0 || roll < (held > 300 ? 30 : 55)) begin
            b.op = fosm_pkg::OP_INSERT;
            case ($urandom_range(0, 3))
                0: b.key = 17'($urandom_range(1, 16));
                1: b.key = 17'($urandom_range(UNIVERSE - 15, UNIVERSE));
                2: b.key = 17'(1 << $urandom_range(0, 16));
                default: b.key = 17'($urandom_range(1, UNIVERSE));
            endcase
        end else begin
            b.op = fosm_pkg::OP_TAKE;
            case ($urandom_range(0, 3))
                0: b.rank = 1;
                1: b.rank = held;
                default: b.rank = $urandom_range(1, held);
            endcase
        end
        return b;
    endfunction

    initial begin
        int unsigned wait_n;
        int unsigned beats;
        beats = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 50 == 0) calm_out = ($urandom_range(0, 3) == 0);
            wait_n = calm_out ? 0 : $urandom_range(0, 7);
            if (wait_n > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            beats++;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty store and bad fields
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd1);
        send_op(fosm_pkg::OP_TAKE,   17'd5,      32'd0);
        send_op(fosm_pkg::OP_INSERT, 17'd0,      32'd7);
        send_op(fosm_pkg::OP_INSERT, 17'd65537,  32'd0);
        send_op(fosm_pkg::OP_INSERT, 17'h1FFFF,  32'hFFFF_FFFF);
        // key extremes and a duplicate
        send_op(fosm_pkg::OP_INSERT, 17'd1,      32'd0);
        send_op(fosm_pkg::OP_INSERT, 17'd65536,  32'd0);
        send_op(fosm_pkg::OP_INSERT, 17'd1,      32'h5A5A_5A5A);
        send_op(fosm_pkg::OP_INSERT, 17'd32768,  32'd0);
        send_op(fosm_pkg::OP_INSERT, 17'd2,      32'hFFFF_FFFF);
        // rank out of range with a populated store
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd0);
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd6);
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'hFFFF_FFFF);
        // take top and bottom until empty, then one take from the empty store
        send_op(fosm_pkg::OP_TAKE,   17'h1FFFF,  32'd5);
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd1);
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd1);
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd2);
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd1);
        send_op(fosm_pkg::OP_TAKE,   17'd0,      32'd1);

        repeat (RANDOM_ITEMS) send_request(random_request());

        i_in_valid <= 1'b0;
        while (board.pending_answers.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (board.errors == 0 && board.pending_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
